@@ rtl/cic_pkg.sv @@
// Package for the chain integer calculator.
// Holds command codes and the command/status structs between controller and datapath.
// No dependencies.
package cic_pkg;

  localparam logic [2:0] CMD_LOAD  = 3'd0;
  localparam logic [2:0] CMD_ADD   = 3'd1;
  localparam logic [2:0] CMD_SUB   = 3'd2;
  localparam logic [2:0] CMD_MUL   = 3'd3;
  localparam logic [2:0] CMD_DIV   = 3'd4;
  localparam logic [2:0] CMD_ROOT  = 3'd5;
  localparam logic [2:0] CMD_POWER = 3'd6;
  localparam logic [2:0] CMD_CHECK = 3'd7;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_START,
    OP_SIMPLE,
    OP_DIV_STEP,
    OP_DIV_DONE,
    OP_POW_STEP,
    OP_ROOT_MID,
    OP_ROOT_PSTEP,
    OP_ROOT_DECIDE,
    OP_ROOT_ONE
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic div_zero;
    logic div_last;
    logic pow_trivial;
    logic pow_last;
    logic root_trivial;
    logic root_empty;
    logic root_exact;
    logic root_pdone;
  } dp_sts_t;

endpackage

@@ rtl/chain_integer_calculator.sv @@
// Top level of the chain integer calculator.
// Instantiates cic_ctrl and cic_datapath; depends on cic_pkg.
//
// One request at a time, one result per request. Load, add, sub, mul and
// check are done in the dispatch state; divide produces one quotient bit
// a cycle; power runs one square-and-multiply step per exponent bit up to
// its top set bit (at most 31); root runs a binary search over
// 1..accumulator, each probe raising the midpoint to the degree by
// repeated multiplication until the partial power passes the accumulator.
// The result holds until taken.
module chain_integer_calculator #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [2:0]                   command_i,
  input  logic signed [31:0]           operand_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [DATA_WIDTH-1:0] accumulator_value_o,
  output logic                         inexact_division_o,
  output logic                         divide_by_zero_o,
  output logic                         check_mismatch_o
);
  import cic_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  cic_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .command_i,
    .out_valid_o, .out_stall_i, .sts_i(dp_sts), .cmd_o(dp_cmd)
  );

  cic_datapath #(.DataWidth(DATA_WIDTH)) u_dp (
    .clk_i, .rst_ni, .cmd_i(dp_cmd), .command_i, .operand_i, .sts_o(dp_sts),
    .acc_o(accumulator_value_o), .inexact_o(inexact_division_o),
    .dz_o(divide_by_zero_o), .mism_o(check_mismatch_o)
  );

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("request accepted while result pending");
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $countones({inexact_division_o, divide_by_zero_o,
                                check_mismatch_o}) <= 1)
    else $error("multiple flags set");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(accumulator_value_o))
    else $error("result changed while stalled");

endmodule

@@ rtl/cic_datapath.sv @@
// Datapath of the chain integer calculator: accumulator, shift-subtract
// divider, square-and-multiply power unit and binary-search root unit.
// Depends on cic_pkg.
module cic_datapath #(
  parameter int DataWidth = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cic_pkg::dp_cmd_t            cmd_i,
  input  logic [2:0]                  command_i,
  input  logic signed [31:0]          operand_i,
  output cic_pkg::dp_sts_t            sts_o,
  output logic signed [DataWidth-1:0] acc_o,
  output logic                        inexact_o,
  output logic                        dz_o,
  output logic                        mism_o
);
  import cic_pkg::*;

  localparam int CntW = $clog2(DataWidth + 1);
  localparam int ECntW = 6;

  logic [DataWidth-1:0] acc_q, acc_d;
  logic [2:0]           cmd_q, cmd_d;
  logic [31:0]          op_q, op_d;
  logic [DataWidth-1:0] val_q, val_d;
  logic                 inx_q, inx_d, dz_q, dz_d, mm_q, mm_d;
  logic [DataWidth-1:0] ua_q, ua_d, ub_q, ub_d;
  logic [DataWidth:0]   rem_q, rem_d;
  logic                 neg_q, neg_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [DataWidth-1:0] pr_q, pr_d, pb_q, pb_d;
  logic [31:0]          pe_q, pe_d;
  logic [ECntW-1:0]     ec_q, ec_d;
  logic [DataWidth-1:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [DataWidth:0]   racc_q, racc_d;
  logic                 rovf_q, rovf_d;
  logic [31:0]          rk_q, rk_d;

  logic [DataWidth-1:0] opval;
  logic [2*DataWidth-1:0] mul_full, sq_full;
  logic [2*DataWidth-1:0] rmul_full;
  logic [DataWidth:0]   rem_sh, rem_sub;
  logic [DataWidth:0]   hi_ext, lo_ext;

  assign opval = DataWidth'({{32{operand_i[31]}}, operand_i});

  always_comb begin
    mul_full  = (2*DataWidth)'(pr_q) * (2*DataWidth)'(pb_q);
    sq_full   = (2*DataWidth)'(pb_q) * (2*DataWidth)'(pb_q);
    rmul_full = (2*DataWidth)'(racc_q[DataWidth-1:0]) * (2*DataWidth)'(mid_q);
    rem_sh    = {rem_q[DataWidth-1:0], ua_q[DataWidth-1]};
    rem_sub   = rem_sh - {1'b0, ub_q};
    hi_ext    = {1'b0, hi_q};
    lo_ext    = {1'b0, lo_q};
  end

  always_comb begin
    acc_d = acc_q; cmd_d = cmd_q; op_d = op_q; val_d = val_q;
    inx_d = inx_q; dz_d = dz_q; mm_d = mm_q;
    ua_d = ua_q; ub_d = ub_q; rem_d = rem_q; neg_d = neg_q; cnt_d = cnt_q;
    pr_d = pr_q; pb_d = pb_q; pe_d = pe_q; ec_d = ec_q;
    lo_d = lo_q; hi_d = hi_q; mid_d = mid_q;
    racc_d = racc_q; rovf_d = rovf_q; rk_d = rk_q;
    unique case (cmd_i.op)
      OP_START: begin
        cmd_d = command_i; op_d = operand_i; val_d = opval;
        inx_d = 1'b0; dz_d = 1'b0; mm_d = 1'b0;
        ua_d = acc_q[DataWidth-1] ? -acc_q : acc_q;
        ub_d = opval[DataWidth-1] ? -opval : opval;
        neg_d = acc_q[DataWidth-1] ^ opval[DataWidth-1];
        rem_d = '0;
        cnt_d = CntW'(DataWidth);
        pr_d = (command_i == CMD_MUL) ? opval : DataWidth'(1);
        pb_d = acc_q; pe_d = operand_i;
        ec_d = '0;
        lo_d = DataWidth'(1); hi_d = acc_q;
      end
      OP_SIMPLE: begin
        unique case (cmd_q)
          CMD_LOAD: acc_d = val_q;
          CMD_ADD:  acc_d = acc_q + val_q;
          CMD_SUB:  acc_d = acc_q - val_q;
          CMD_MUL:  acc_d = mul_full[DataWidth-1:0];
          CMD_DIV:  dz_d = 1'b1;
          CMD_POWER: acc_d = DataWidth'(1);
          CMD_ROOT: acc_d = '0;
          default:  mm_d = (acc_q != val_q);
        endcase
      end
      OP_DIV_STEP: begin
        ua_d = {ua_q[DataWidth-2:0], 1'b0};
        if (!rem_sub[DataWidth]) begin
          rem_d = rem_sub; ua_d[0] = 1'b1;
        end else begin
          rem_d = rem_sh;
        end
        cnt_d = cnt_q - CntW'(1);
      end
      OP_DIV_DONE: begin
        acc_d = neg_q ? -ua_q : ua_q;
        inx_d = (rem_q != '0);
      end
      OP_POW_STEP: begin
        if (pe_q[0]) pr_d = mul_full[DataWidth-1:0];
        pb_d = sq_full[DataWidth-1:0];
        pe_d = pe_q >> 1;
        ec_d = ec_q + ECntW'(1);
        if (ec_q == ECntW'(31) || (pe_q >> 1) == '0) begin
          acc_d = pe_q[0] ? mul_full[DataWidth-1:0] : pr_q;
        end
      end
      OP_ROOT_MID: begin
        mid_d = DataWidth'((lo_ext + hi_ext) >> 1);
        racc_d = (DataWidth+1)'(1); rovf_d = 1'b0; rk_d = op_q;
      end
      OP_ROOT_PSTEP: begin
        if (!rovf_q) begin
          if (rmul_full > (2*DataWidth)'(val_q)) rovf_d = 1'b1;
          else racc_d = rmul_full[DataWidth:0];
        end
        rk_d = rk_q - 32'd1;
      end
      OP_ROOT_DECIDE: begin
        if (sts_o.root_exact) acc_d = mid_q;
        else if (rovf_q || racc_q > {1'b0, val_q}) hi_d = mid_q - DataWidth'(1);
        else lo_d = mid_q + DataWidth'(1);
      end
      OP_ROOT_ONE: acc_d = '0;
      default: ;
    endcase
    if (cmd_i.op == OP_START) val_d = (command_i == CMD_ROOT) ? acc_q : opval;
  end

  always_comb begin
    sts_o.div_zero     = (val_q == '0);
    sts_o.div_last     = (cnt_q == CntW'(1));
    sts_o.pow_trivial  = (op_q == 32'd0) || op_q[31];
    sts_o.pow_last     = (ec_q == ECntW'(31)) || ((pe_q >> 1) == '0);
    sts_o.root_trivial = (val_q == '0) || val_q[DataWidth-1] ||
                         (op_q == 32'd0) || op_q[31];
    sts_o.root_empty   = (lo_q > hi_q) || (hi_q == '1);
    sts_o.root_exact   = !rovf_q && (racc_q == {1'b0, val_q});
    // a probe of 1 never grows, so it needs no multiply steps
    sts_o.root_pdone   = (rk_q == 32'd0) || rovf_q || (mid_q <= DataWidth'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0; inx_q <= 1'b0; dz_q <= 1'b0; mm_q <= 1'b0;
    end else begin
      acc_q <= acc_d; inx_q <= inx_d; dz_q <= dz_d; mm_q <= mm_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; op_q <= op_d; val_q <= val_d;
    ua_q <= ua_d; ub_q <= ub_d; rem_q <= rem_d; neg_q <= neg_d; cnt_q <= cnt_d;
    pr_q <= pr_d; pb_q <= pb_d; pe_q <= pe_d; ec_q <= ec_d;
    lo_q <= lo_d; hi_q <= hi_d; mid_q <= mid_d;
    racc_q <= racc_d; rovf_q <= rovf_d; rk_q <= rk_d;
  end

  assign acc_o = acc_q;
  assign inexact_o = inx_q;
  assign dz_o = dz_q;
  assign mism_o = mm_q;

endmodule

@@ rtl/cic_ctrl.sv @@
// Controller of the chain integer calculator: sequences the datapath
// and runs the request handshakes. Depends on cic_pkg.
module cic_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [2:0]            command_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  cic_pkg::dp_sts_t      sts_i,
  output cic_pkg::dp_cmd_t      cmd_o
);
  import cic_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_DIV    = 4'd2;
  localparam logic [3:0] S_DIVFIN = 4'd3;
  localparam logic [3:0] S_POW    = 4'd4;
  localparam logic [3:0] S_RMID   = 4'd5;
  localparam logic [3:0] S_RPOW   = 4'd6;
  localparam logic [3:0] S_RDEC   = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;
  localparam logic [3:0] S_RCHK   = 4'd9;

  logic [3:0] state_q, state_d;
  logic [2:0] c_q, c_d;
  logic       accept;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign accept      = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    c_d = c_q;
    cmd_o.op = OP_NONE;
    unique case (state_q)
      S_IDLE: if (accept) begin
        cmd_o.op = OP_START; c_d = command_i; state_d = S_DISP;
      end
      S_DISP: begin
        priority if (c_q == CMD_DIV && !sts_i.div_zero) state_d = S_DIV;
        else if (c_q == CMD_POWER && !sts_i.pow_trivial) state_d = S_POW;
        else if (c_q == CMD_ROOT && !sts_i.root_trivial) state_d = S_RMID;
        else begin
          cmd_o.op = OP_SIMPLE; state_d = S_OUT;
        end
      end
      S_DIV: begin
        cmd_o.op = OP_DIV_STEP;
        if (sts_i.div_last) state_d = S_DIVFIN;
      end
      S_DIVFIN: begin
        cmd_o.op = OP_DIV_DONE; state_d = S_OUT;
      end
      S_POW: begin
        cmd_o.op = OP_POW_STEP;
        if (sts_i.pow_last) state_d = S_OUT;
      end
      S_RCHK: begin
        if (sts_i.root_empty) begin
          cmd_o.op = OP_ROOT_ONE; state_d = S_OUT;
        end else state_d = S_RMID;
      end
      S_RMID: begin
        cmd_o.op = OP_ROOT_MID; state_d = S_RPOW;
      end
      S_RPOW: begin
        if (sts_i.root_pdone) state_d = S_RDEC;
        else cmd_o.op = OP_ROOT_PSTEP;
      end
      S_RDEC: begin
        cmd_o.op = OP_ROOT_DECIDE;
        state_d = sts_i.root_exact ? S_OUT : S_RCHK;
      end
      S_OUT: if (!out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; c_q <= CMD_LOAD;
    end else begin
      state_q <= state_d; c_q <= c_d;
    end
  end

endmodule
